### rtl/core/kvs_pkg.sv
package kvs_pkg;

  localparam int MAX_KEYS    = 64;
  localparam int IDX_W       = $clog2(MAX_KEYS);
  localparam int NK_W        = $clog2(MAX_KEYS + 1);
  localparam int KEY_COUNT_W = 7;
  localparam int TICK_W      = 48;
  localparam int MOD_STEPS   = TICK_W;
  localparam int FRAC_STEPS  = 16;
  localparam int STEP_W      = $clog2(MOD_STEPS);

  localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd0;
  localparam logic [1:0] CFG_LOOP_ENABLE      = 2'd1;
  localparam logic [1:0] CFG_KEY_COUNT        = 2'd2;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_ACCEPT,
    OP_MUL,
    OP_CAP_LAST,
    OP_MOD_STEP,
    OP_MOD_DONE,
    OP_SRCH_CMP,
    OP_FRAC_STEP,
    OP_LERP_MUL,
    OP_LERP_SUM,
    OP_OUT_LAST,
    OP_ZERO
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] rd_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic [NK_W-1:0] n;
    logic            lt_zero;
    logic            loop;
    logic            found;
  } dp_status_t;

endpackage

### rtl/core/keyframe_vector_sampler_unit.sv
// Keyframe write: taken while idle, the next transfer is taken in the following cycle.
// Advance: the work up to out_valid runs through the 48-step modulo of the tick in
// loop mode, the linear key search over the key RAM port (a read state and a compare
// state per key) and the 16-step fraction divide. One advance is in work at a time.
// Reset (rst, synchronous): config registers to their defaults, clock to zero; the key RAM is not cleared.
module keyframe_vector_sampler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [5:0]  key_index,
  input  logic [31:0] key_time,
  input  logic [31:0] key_x,
  input  logic [31:0] key_y,
  input  logic [31:0] key_z,
  input  logic [31:0] delta_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import kvs_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  kvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  kvs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .key_index  (key_index),
    .key_time   (key_time),
    .key_x      (key_x),
    .key_y      (key_y),
    .key_z      (key_z),
    .delta_time (delta_time),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .dp_cmd     (dp_cmd),
    .dp_status  (dp_status)
  );

endmodule

### rtl/core/kvs_ram.sv
module kvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/kvs_ctrl.sv
module kvs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output kvs_pkg::dp_cmd_t    dp_cmd,
  input  kvs_pkg::dp_status_t dp_status
);
  import kvs_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_MUL     = 13'b0000000000010,
    S_LAST    = 13'b0000000000100,
    S_MOD     = 13'b0000000001000,
    S_MODFIN  = 13'b0000000010000,
    S_SRQ     = 13'b0000000100000,
    S_SCMP    = 13'b0000001000000,
    S_FRAC    = 13'b0000010000000,
    S_LMUL    = 13'b0000100000000,
    S_LSUM    = 13'b0001000000000,
    S_LASTOUT = 13'b0010000000000,
    S_ZERO    = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_t;

  state_t            state, state_next;
  logic [NK_W-1:0]   idx, idx_next;
  logic [STEP_W-1:0] step, step_next;
  logic [NK_W-1:0]   last;

  assign last      = dp_status.n - NK_W'(1);
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    step_next      = step;
    dp_cmd.op      = OP_NONE;
    dp_cmd.rd_addr = idx[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_WRITE) begin
            dp_cmd.op = OP_WRITE;
          end else begin
            dp_cmd.op  = OP_ACCEPT;
            state_next = (dp_status.n == '0) ? S_ZERO : S_MUL;
          end
        end
      end
      S_MUL: begin
        dp_cmd.op      = OP_MUL;
        dp_cmd.rd_addr = last[IDX_W-1:0];
      end
      default: ;
    endcase
    case (state)
      S_MUL: state_next = S_LAST;
      S_LAST: begin
        dp_cmd.op = OP_CAP_LAST;
        idx_next  = '0;
        step_next = '0;
        if (!dp_status.lt_zero && dp_status.loop) begin
          state_next = S_MOD;
        end else begin
          state_next = S_SRQ;
        end
      end
      S_MOD: begin
        dp_cmd.op = OP_MOD_STEP;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(MOD_STEPS - 1)) begin
          state_next = S_MODFIN;
        end
      end
      S_MODFIN: begin
        dp_cmd.op  = OP_MOD_DONE;
        state_next = S_SRQ;
      end
      S_SRQ: state_next = S_SCMP;
      S_SCMP: begin
        dp_cmd.op = OP_SRCH_CMP;
        step_next = '0;
        if (dp_status.found) begin
          state_next = (idx == '0) ? S_LASTOUT : S_FRAC;
        end else if (idx + NK_W'(1) == dp_status.n) begin
          state_next = S_LASTOUT;
        end else begin
          idx_next   = idx + NK_W'(1);
          state_next = S_SRQ;
        end
      end
      S_FRAC: begin
        dp_cmd.op = OP_FRAC_STEP;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(FRAC_STEPS - 1)) begin
          state_next = S_LMUL;
        end
      end
      S_LMUL: begin
        dp_cmd.op  = OP_LERP_MUL;
        state_next = S_LSUM;
      end
      S_LSUM: begin
        dp_cmd.op  = OP_LERP_SUM;
        state_next = S_OUT;
      end
      S_LASTOUT: begin
        dp_cmd.op  = OP_OUT_LAST;
        state_next = S_OUT;
      end
      S_ZERO: begin
        dp_cmd.op  = OP_ZERO;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      step  <= step_next;
    end
  end

endmodule

### rtl/core/kvs_datapath.sv
module kvs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [5:0]          key_index,
  input  logic [31:0]         key_time,
  input  logic [31:0]         key_x,
  input  logic [31:0]         key_y,
  input  logic [31:0]         key_z,
  input  logic [31:0]         delta_time,
  output logic [31:0]         out_x,
  output logic [31:0]         out_y,
  output logic [31:0]         out_z,
  input  kvs_pkg::dp_cmd_t    dp_cmd,
  output kvs_pkg::dp_status_t dp_status
);
  import kvs_pkg::*;

  logic [31:0]            ticks_per_second;
  logic                   loop_enable;
  logic [KEY_COUNT_W-1:0] key_count;
  logic [31:0]            elapsed_time;
  logic [63:0]            prod;
  logic [TICK_W-1:0]      tick;
  logic [31:0]            rem;
  logic [31:0]            div;
  logic [TICK_W-1:0]      sreg;
  logic [31:0]            last_x, last_y, last_z;
  logic [31:0]            prev_t, prev_x, prev_y, prev_z;
  logic [31:0]            b_x, b_y, b_z;
  logic signed [49:0]     p_x, p_y, p_z;

  logic [127:0]      rd_data;
  logic [31:0]       rd_t, rd_x, rd_y, rd_z;
  logic              we;
  logic [32:0]       sum;
  logic [32:0]       rem_sh;
  logic              ge;
  logic [31:0]       rem_new;
  logic [31:0]       kc32;
  logic [TICK_W-1:0] tick_raw;
  logic signed [16:0] frac_s;

  assign we = (dp_cmd.op == OP_WRITE) && (32'(key_index) < MAX_KEYS);

  kvs_ram #(.WIDTH(128), .DEPTH(MAX_KEYS)) u_keys (
    .clk   (clk),
    .we    (we),
    .waddr (IDX_W'(key_index)),
    .wdata ({key_time, key_x, key_y, key_z}),
    .raddr (dp_cmd.rd_addr),
    .rdata (rd_data)
  );

  assign rd_t = rd_data[127:96];
  assign rd_x = rd_data[95:64];
  assign rd_y = rd_data[63:32];
  assign rd_z = rd_data[31:0];

  assign sum      = {1'b0, elapsed_time} + {1'b0, delta_time};
  assign rem_sh   = {rem, sreg[TICK_W-1]};
  assign ge       = rem_sh >= {1'b0, div};
  assign rem_new  = ge ? 32'(rem_sh - {1'b0, div}) : rem_sh[31:0];
  assign kc32     = 32'(key_count);
  assign tick_raw = prod[63:16];
  assign frac_s   = signed'({1'b0, sreg[15:0]});

  assign dp_status.n       = NK_W'((kc32 > MAX_KEYS) ? MAX_KEYS : kc32);
  assign dp_status.lt_zero = (rd_t == '0);
  assign dp_status.loop    = loop_enable;
  assign dp_status.found   = {16'b0, rd_t} > tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= 32'd65536;
      loop_enable      <= 1'b1;
      key_count        <= '0;
      elapsed_time     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
          CFG_LOOP_ENABLE:      loop_enable      <= cfg_data[0];
          CFG_KEY_COUNT:        key_count        <= cfg_data[KEY_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (dp_cmd.op == OP_ACCEPT) begin
        elapsed_time <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      OP_MUL: prod <= elapsed_time * ticks_per_second;
      OP_CAP_LAST: begin
        last_x <= rd_x;
        last_y <= rd_y;
        last_z <= rd_z;
        if (rd_t == '0) begin
          tick <= '0;
        end else if (loop_enable) begin
          sreg <= tick_raw;
          rem  <= '0;
          div  <= rd_t;
        end else begin
          tick <= (tick_raw > TICK_W'(rd_t)) ? TICK_W'(rd_t) : tick_raw;
        end
      end
      OP_MOD_STEP, OP_FRAC_STEP: begin
        rem  <= rem_new;
        sreg <= {sreg[TICK_W-2:0], ge};
      end
      OP_MOD_DONE: tick <= TICK_W'(rem);
      OP_SRCH_CMP: begin
        if (dp_status.found) begin
          rem  <= 32'(tick - TICK_W'(prev_t));
          div  <= rd_t - prev_t;
          sreg <= '0;
          b_x  <= rd_x;
          b_y  <= rd_y;
          b_z  <= rd_z;
        end else begin
          prev_t <= rd_t;
          prev_x <= rd_x;
          prev_y <= rd_y;
          prev_z <= rd_z;
        end
      end
      OP_LERP_MUL: begin
        p_x <= (signed'({b_x[31], b_x}) - signed'({prev_x[31], prev_x})) * frac_s;
        p_y <= (signed'({b_y[31], b_y}) - signed'({prev_y[31], prev_y})) * frac_s;
        p_z <= (signed'({b_z[31], b_z}) - signed'({prev_z[31], prev_z})) * frac_s;
      end
      OP_LERP_SUM: begin
        out_x <= prev_x + p_x[47:16];
        out_y <= prev_y + p_y[47:16];
        out_z <= prev_z + p_z[47:16];
      end
      OP_OUT_LAST: begin
        out_x <= last_x;
        out_y <= last_y;
        out_z <= last_z;
      end
      OP_ZERO: begin
        out_x <= '0;
        out_y <= '0;
        out_z <= '0;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/kvs_checker.sv
module kvs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        cmd,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z
);
  import kvs_pkg::*;

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result waits");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_WRITE) |=> (!out_valid && !in_stall))
    else $error("keyframe write disturbed the idle state");

  a_advance_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_ADVANCE) |=> (in_stall && !out_valid))
    else $error("advance did not start work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_y)
                                  && $stable(out_z)))
    else $error("stalled result changed");

endmodule

bind keyframe_vector_sampler_unit kvs_checker u_kvs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z)
);

### dv/keyframe_vector_sampler_unit_tb.sv
`timescale 1ns / 1ps

module keyframe_vector_sampler_unit_tb;
  import kvs_pkg::*;

  class sample_board;
    logic [31:0] q_x[$];
    logic [31:0] q_y[$];
    logic [31:0] q_z[$];
    logic [31:0] tps;
    logic        looping;
    logic [6:0]  nkeys;
    logic [31:0] clock_s;
    logic [31:0] kt[MAX_KEYS];
    logic [31:0] kx[MAX_KEYS];
    logic [31:0] ky[MAX_KEYS];
    logic [31:0] kz[MAX_KEYS];
    int          errors;

    function new();
      tps = 32'd65536;
      looping = 1'b1;
      nkeys = '0;
      clock_s = '0;
      errors = 0;
      foreach (kt[i]) begin
        kt[i] = '0; kx[i] = '0; ky[i] = '0; kz[i] = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_TICKS_PER_SECOND: tps = data;
        CFG_LOOP_ENABLE:      looping = data[0];
        CFG_KEY_COUNT:        nkeys = data[6:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint unsigned fr);
      longint sa, sb, prod, dl;
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      prod = (sb - sa) * longint'(fr);
      if (prod >= 0) dl = prod >>> 16;
      else dl = -((-prod + 65535) >>> 16);
      return 32'(sa + dl);
    endfunction

    function void note_input(logic c, logic [5:0] idx, logic [31:0] t, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z, logic [31:0] dt);
      longint unsigned sum, tick, lt, t0, t1, fr;
      int n, last, nxt;
      bit found;
      if (c == CMD_WRITE) begin
        kt[idx] = t; kx[idx] = x; ky[idx] = y; kz[idx] = z;
        return;
      end
      sum = longint'(clock_s) + longint'(dt);
      clock_s = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      n = (nkeys > MAX_KEYS) ? MAX_KEYS : nkeys;
      if (n == 0) begin
        q_x.push_back('0); q_y.push_back('0); q_z.push_back('0);
        return;
      end
      last = n - 1;
      tick = (longint'(clock_s) * longint'(tps)) >> 16;
      lt = kt[last];
      if (lt == 0) tick = 0;
      else if (looping) tick = tick % lt;
      else if (tick > lt) tick = lt;
      found = 0;
      nxt = 0;
      for (int i = 0; i < n; i++)
        if (!found && longint'(kt[i]) > tick) begin
          nxt = i; found = 1;
        end
      if (!found || nxt == 0) begin
        q_x.push_back(kx[last]); q_y.push_back(ky[last]); q_z.push_back(kz[last]);
        return;
      end
      t0 = kt[nxt-1];
      t1 = kt[nxt];
      fr = ((tick - t0) << 16) / (t1 - t0);
      q_x.push_back(blend(kx[nxt-1], kx[nxt], fr));
      q_y.push_back(blend(ky[nxt-1], ky[nxt], fr));
      q_z.push_back(blend(kz[nxt-1], kz[nxt], fr));
    endfunction

    function void check_sample(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [31:0] ex, ey, ez;
      if (q_x.size() == 0) begin
        $display("%0t: unexpected sample %h %h %h", $time, x, y, z);
        errors++;
        return;
      end
      ex = q_x.pop_front(); ey = q_y.pop_front(); ez = q_z.pop_front();
      if (x !== ex) begin
        $display("%0t: out_x expected %h actual %h", $time, ex, x); errors++;
      end
      if (y !== ey) begin
        $display("%0t: out_y expected %h actual %h", $time, ey, y); errors++;
      end
      if (z !== ez) begin
        $display("%0t: out_z expected %h actual %h", $time, ez, z); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = 1'b0;
  logic [5:0]  key_index = '0;
  logic [31:0] key_time = '0;
  logic [31:0] key_x = '0;
  logic [31:0] key_y = '0;
  logic [31:0] key_z = '0;
  logic [31:0] delta_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_x, out_y, out_z;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sample_board board = new();
  int  cycles = 0;
  bit  rx_on = 1'b0;
  int  rx_gap = 0;
  bit  rx_calm = 1'b0;

  always #10 clk = ~clk;

  keyframe_vector_sampler_unit u_top (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall && rx_on) board.check_sample(out_x, out_y, out_z);
    if (!rx_on) out_stall <= 1'b0;
    else if (out_valid && !out_stall) begin
      rx_gap = rx_calm ? 0 : $urandom_range(0, 3);
      out_stall <= (rx_gap != 0);
    end else if (out_stall) begin
      rx_gap = rx_gap - 1;
      out_stall <= (rx_gap > 0);
    end
  end

  always @(posedge clk)
    if ($urandom_range(0, 199) == 0) rx_calm <= ~rx_calm;

  task automatic send_item(logic c, logic [5:0] idx, logic [31:0] t, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z, logic [31:0] dt);
    int gap;
    gap = rx_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c; key_index <= idx; key_time <= t;
    key_x <= x; key_y <= y; key_z <= z; delta_time <= dt;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_input(c, idx, t, x, y, z, dt);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_index <= idx; cfg_data <= data; cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.q_x.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic load_table(int n, bit wide);
    logic [31:0] t;
    t = 0;
    for (int i = 0; i < n; i++) begin
      if (i == 0 && $urandom_range(0, 3) == 0) t = 0;
      else if (i == 0) t = $urandom_range(0, 32'h3_0000);
      else t = t + (wide ? $urandom : $urandom_range(0, 32'h4_0000));
      if ($urandom_range(0, 9) == 0 && i > 0) t = t;
      send_item(CMD_WRITE, 6'(i), t, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  logic [31:0] tps_pick;
  int n;

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    rx_on = 1'b1;

    send_item(CMD_ADVANCE, 6'd0, '0, '0, '0, '0, 32'h0001_0000);
    send_item(CMD_WRITE, 6'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, '0);
    send_item(CMD_WRITE, 6'd1, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
              '0);
    send_item(CMD_WRITE, 6'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001,
              '0);
    send_item(CMD_WRITE, 6'd63, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, '0);
    settle();
    write_reg(CFG_KEY_COUNT, 32'd3);
    write_reg(CFG_LOOP_ENABLE, 32'd0);
    write_reg(CFG_TICKS_PER_SECOND, 32'h0001_0000);
    send_item(CMD_ADVANCE, 6'd5, '0, '0, '0, '0, 32'h0000_8000);
    send_item(CMD_ADVANCE, 6'd5, '0, '0, '0, '0, 32'h0001_8000);
    send_item(CMD_ADVANCE, 6'd5, '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(CMD_ADVANCE, 6'd5, '0, '0, '0, '0, 32'hFFFF_FFFF);
    settle();
    write_reg(CFG_TICKS_PER_SECOND, 32'hFFFF_FFFF);
    write_reg(CFG_LOOP_ENABLE, 32'd1);
    send_item(CMD_ADVANCE, 6'd0, '0, '0, '0, '0, 32'd0);
    settle();
    write_reg(CFG_TICKS_PER_SECOND, 32'd0);
    send_item(CMD_ADVANCE, 6'd0, '0, '0, '0, '0, 32'd1);
    settle();
    write_reg(CFG_KEY_COUNT, 32'd1);
    send_item(CMD_ADVANCE, 6'd0, '0, '0, '0, '0, 32'd1);
    settle();

    for (int ph = 0; ph < 40; ph++) begin
      n = (ph % 10 == 9) ? 64 : $urandom_range(1, 8);
      rst <= 1'b0;
      load_table(n, ph % 4 == 3);
      settle();
      case ($urandom_range(0, 3))
        0: tps_pick = 32'h0001_0000;
        1: tps_pick = $urandom_range(0, 32'h0010_0000);
        2: tps_pick = 32'hFFFF_FFFF;
        default: tps_pick = $urandom;
      endcase
      write_reg(CFG_TICKS_PER_SECOND, tps_pick);
      write_reg(CFG_LOOP_ENABLE, 32'($urandom_range(0, 1)));
      write_reg(CFG_KEY_COUNT, (ph % 13 == 5) ? 32'd0 :
                               (ph % 10 == 9) ? 32'd64 : 32'(n));
      for (int k = 0; k < 40; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(CMD_WRITE, 6'($urandom_range(0, n - 1)), $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        else
          send_item(CMD_ADVANCE, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
                    ($urandom_range(0, 7) == 0) ? $urandom :
                    32'($urandom_range(0, 32'h0000_C000)));
      end
      settle();
    end

    settle();
    if (board.errors == 0 && board.q_x.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### keyframe_vector_sampler_unit.f
rtl/core/kvs_pkg.sv
rtl/core/kvs_ram.sv
rtl/core/kvs_ctrl.sv
rtl/core/kvs_datapath.sv
rtl/core/keyframe_vector_sampler_unit.sv
rtl/core/kvs_checker.sv
dv/keyframe_vector_sampler_unit_tb.sv
